// File: hdl/ctsu_pkg.sv
// ----------------------------------------------------------------------------
// ctsu_pkg
// Types, constants and helper functions shared by the credit thread scheduler.
// ----------------------------------------------------------------------------
package ctsu_pkg;

  localparam int NUM_THREADS = 16;
  localparam int TID_W = $clog2(NUM_THREADS);
  localparam int CNT_W = $clog2(NUM_THREADS + 1);
  localparam logic [5:0] IDLE_ID = 6'd32;

  // Floor of x / 100 as (x * DIV100_MUL) >> DIV100_SHIFT, exact for x up to 2^16.
  localparam int DIV100_MUL = 83887;
  localparam int DIV100_SHIFT = 23;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_YIELD  = 3'd1;
  localparam logic [2:0] KIND_BLOCK  = 3'd2;
  localparam logic [2:0] KIND_CREATE = 3'd3;
  localparam logic [2:0] KIND_SLEEP  = 3'd4;
  localparam logic [2:0] KIND_CANCEL = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  priority_req;
    logic [15:0] sleep_ms;
    logic [4:0]  target_thread;
  } cmd_t;

  typedef struct packed {
    logic [5:0] running_thread;
    logic [4:0] created_thread;
    logic       failed;
  } rsp_t;

  // Index of the lowest set bit, or IDLE_ID when none is set.
  function automatic logic [5:0] lowest_set(input logic [31:0] m);
    logic [5:0] idx;
    idx = IDLE_ID;
    for (int i = 31; i >= 0; i--) begin
      if (m[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  // Index of the highest clear bit, or IDLE_ID when all are set.
  function automatic logic [5:0] highest_clear(input logic [31:0] m);
    logic [5:0] idx;
    idx = IDLE_ID;
    for (int i = 0; i < 32; i++) begin
      if (!m[i]) idx = 6'(i);
    end
    return idx;
  endfunction

  function automatic logic is_slot(input logic [5:0] t);
    return t < 6'(NUM_THREADS);
  endfunction

endpackage

// File: hdl/credit_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// credit_thread_scheduler_unit
// Bitmap thread scheduler with per-thread priority and signed credit kept in
// two small synchronous memories.
// ----------------------------------------------------------------------------
//  Channel   | Ports                | Handshake
//  ----------+----------------------+-----------------------------------------
//  request   | cmd (cmd_t)          | taken when start is high and busy is low
//  result    | rsp (rsp_t)          | valid for one cycle while done is high
//
// Non-tick requests give their result in the cycle after acceptance. A tick
// walks the slots in S_SCAN, passing through S_SWR for each sleeper to
// write its decremented credit through the single credit memory port, then
// S_CWR to charge the running thread when there is one and S_FIN to pick;
// busy stays high over the walk and the result is registered from S_FIN.
// Reset is synchronous and restores all bitmaps;
// memory entries read as their reset values until first written.
// Results cannot be stalled; busy holds off new requests during a tick.
module credit_thread_scheduler_unit
  import ctsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  cmd_t cmd,
  output logic done,
  output rsp_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_SWR  = 5'b00100,
    S_CWR  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] ready_set, wait_cpu_set, sleeping_set, allocated_set, canceled_set;
  logic [7:0]  credit_limit;
  logic [5:0]  current_thread;
  logic [CNT_W-1:0] scan_idx;

  // Memories and their valid bits.
  logic [7:0]  pri_mem  [NUM_THREADS];
  logic [15:0] cred_mem [NUM_THREADS];
  logic [NUM_THREADS-1:0] pri_valid, cred_valid;
  logic [7:0]  pri_q;
  logic [15:0] cred_q;
  logic        pri_vq, cred_vq;
  logic [TID_W-1:0] rd_addr_q;

  logic [TID_W-1:0] rd_addr;
  logic             pri_we, cred_we;
  logic [TID_W-1:0] wr_addr;
  logic [15:0]      cred_wdata;
  logic [7:0]       pri_wdata;

  logic accept;
  logic cur_slot;
  logic [31:0] cur_bit;
  logic [31:0] pick_src;
  logic [5:0]  pick_idx;
  logic [31:0] pick_rest;

  logic [5:0]  new_idx;
  logic        new_ok;
  logic [7:0]  new_limit;
  logic [16:0] ms_plus;
  logic [33:0] ms_prod;
  logic [15:0] sleep_ticks;
  logic        tgt_alloc;
  logic [31:0] tgt_bit;

  logic signed [15:0] cred_eff;
  logic [7:0]         pri_eff;
  logic signed [15:0] dec_val;
  logic signed [17:0] chg_raw, chg_adj;
  logic signed [15:0] chg_sat;
  logic [31:0] fin_ready;
  logic [31:0] scan_bit;

  logic done_next;
  rsp_t rsp_next;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign cur_slot = is_slot(current_thread);
  assign cur_bit  = cur_slot ? (32'd1 << current_thread[4:0]) : 32'd0;
  assign scan_bit = 32'd1 << scan_idx;

  assign new_idx   = (cmd.priority_req == 8'd0) ? lowest_set(~allocated_set)
                                                : highest_clear(allocated_set);
  assign new_ok    = is_slot(new_idx);
  assign new_limit = (credit_limit < cmd.priority_req) ? cmd.priority_req : credit_limit;
  assign ms_plus   = {1'b0, cmd.sleep_ms} + 17'd1;
  assign ms_prod   = 34'(ms_plus) * 34'(DIV100_MUL);
  assign sleep_ticks = 16'(ms_prod >> DIV100_SHIFT);
  assign tgt_alloc = allocated_set[cmd.target_thread];
  assign tgt_bit   = 32'd1 << cmd.target_thread;

  assign cred_eff = cred_vq ? $signed(cred_q) : 16'sd0;
  assign pri_eff  = pri_vq ? pri_q : ((rd_addr_q == '0) ? 8'd1 : 8'd0);
  assign dec_val  = (cred_eff == -16'sd32768) ? cred_eff : cred_eff - 16'sd1;
  assign chg_raw  = 18'(cred_eff) - $signed({10'd0, pri_eff});
  assign chg_adj  = chg_raw[17] ? chg_raw + $signed({10'd0, credit_limit}) : chg_raw;
  assign chg_sat  = (chg_adj > 18'sd32767) ? 16'sd32767 :
                    (chg_adj < -18'sd32768) ? -16'sd32768 : chg_adj[15:0];

  assign fin_ready = (ready_set == 32'd0) ? wait_cpu_set : ready_set;

  always_comb begin
    case (state)
      S_FIN:   pick_src = fin_ready;
      default: pick_src = (cmd.kind == KIND_YIELD) ? (ready_set | cur_bit) : ready_set;
    endcase
    pick_idx  = lowest_set(pick_src);
    pick_rest = (pick_idx == IDLE_ID) ? pick_src : (pick_src & ~(32'd1 << pick_idx[4:0]));
  end

  always_comb begin
    rd_addr = current_thread[TID_W-1:0];
    if (state == S_SCAN && scan_idx < CNT_W'(NUM_THREADS)) begin
      rd_addr = scan_idx[TID_W-1:0];
    end
  end

  always_comb begin
    pri_we     = 1'b0;
    cred_we    = 1'b0;
    wr_addr    = current_thread[TID_W-1:0];
    cred_wdata = 16'(chg_sat);
    pri_wdata  = cmd.priority_req;
    case (state)
      S_IDLE: begin
        if (accept && cmd.kind == KIND_CREATE && new_ok) begin
          pri_we     = 1'b1;
          cred_we    = 1'b1;
          wr_addr    = new_idx[TID_W-1:0];
          cred_wdata = {9'd0, new_limit[7:1]};
        end else if (accept && cmd.kind == KIND_SLEEP && cur_slot) begin
          cred_we    = 1'b1;
          cred_wdata = sleep_ticks;
        end
      end
      S_SWR: begin
        cred_we    = 1'b1;
        wr_addr    = scan_idx[TID_W-1:0];
        cred_wdata = 16'(dec_val);
      end
      S_CWR: begin
        cred_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result of the request finishing in this cycle.
  always_comb begin
    done_next = 1'b0;
    rsp_next  = rsp;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_next  = '{running_thread: current_thread, created_thread: 5'd0, failed: 1'b0};
          done_next = 1'b1;
          case (cmd.kind)
            KIND_TICK: begin
              done_next = 1'b0;
            end
            KIND_YIELD, KIND_BLOCK: begin
              rsp_next.running_thread = pick_idx;
            end
            KIND_CREATE: begin
              if (new_ok) begin
                rsp_next.created_thread = new_idx[4:0];
              end else begin
                rsp_next.failed = 1'b1;
              end
            end
            KIND_CANCEL: begin
              if (!tgt_alloc) rsp_next.failed = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIN: begin
        rsp_next  = '{running_thread: pick_idx, created_thread: 5'd0, failed: 1'b0};
        done_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pri_we) pri_mem[wr_addr] <= pri_wdata;
    if (cred_we) cred_mem[wr_addr] <= cred_wdata;
    pri_q     <= pri_mem[rd_addr];
    cred_q    <= cred_mem[rd_addr];
    rd_addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pri_valid  <= '0;
      cred_valid <= '0;
      pri_vq     <= 1'b0;
      cred_vq    <= 1'b0;
    end else begin
      pri_vq  <= pri_valid[rd_addr];
      cred_vq <= cred_valid[rd_addr];
      if (pri_we) pri_valid[wr_addr] <= 1'b1;
      if (cred_we) cred_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ready_set      <= '0;
      wait_cpu_set   <= '0;
      sleeping_set   <= '0;
      canceled_set   <= '0;
      allocated_set  <= ({32{1'b1}} << NUM_THREADS) | 32'd1;
      credit_limit   <= 8'd1;
      current_thread <= '0;
      scan_idx       <= '0;
      done           <= 1'b0;
      rsp            <= '0;
    end else begin
      done <= done_next;
      rsp  <= rsp_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.kind)
              KIND_TICK: begin
                scan_idx <= '0;
                state    <= S_SCAN;
              end
              KIND_YIELD, KIND_BLOCK: begin
                ready_set      <= pick_rest;
                current_thread <= pick_idx;
              end
              KIND_CREATE: begin
                if (new_ok) begin
                  allocated_set <= allocated_set | (32'd1 << new_idx[4:0]);
                  ready_set     <= ready_set | (32'd1 << new_idx[4:0]);
                  credit_limit  <= new_limit;
                end
              end
              KIND_SLEEP: begin
                sleeping_set <= sleeping_set | cur_bit;
              end
              KIND_CANCEL: begin
                if (tgt_alloc) begin
                  wait_cpu_set <= wait_cpu_set & ~tgt_bit;
                  sleeping_set <= sleeping_set & ~tgt_bit;
                  ready_set    <= ready_set & ~tgt_bit;
                  canceled_set <= canceled_set | tgt_bit;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx == CNT_W'(NUM_THREADS)) begin
            state <= cur_slot ? S_CWR : S_FIN;
          end else if (sleeping_set[scan_idx[TID_W-1:0]]) begin
            state <= S_SWR;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_SWR: begin
          if (dec_val <= 16'sd0) begin
            sleeping_set <= sleeping_set & ~scan_bit;
            ready_set    <= ready_set | scan_bit;
          end
          scan_idx <= scan_idx + 1'b1;
          state    <= S_SCAN;
        end
        S_CWR: begin
          if (chg_raw[17]) begin
            wait_cpu_set <= wait_cpu_set | cur_bit;
          end else begin
            ready_set <= ready_set | cur_bit;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (ready_set == 32'd0) wait_cpu_set <= '0;
          ready_set      <= pick_rest;
          current_thread <= pick_idx;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Canceled bits are kept for visibility of the thread state; nothing reads
  // them back in this event set, so fold them into nothing observable.
  logic unused_canceled;
  assign unused_canceled = ^canceled_set;

endmodule

// File: hdl/ctsu_checker.sv
// ----------------------------------------------------------------------------
// ctsu_checker
// Port-level checks for the credit thread scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ctsu_checker
  import ctsu_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input cmd_t cmd,
  input logic done,
  input rsp_t rsp
);

  // A result always lands as the block returns to accepting requests.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // Every request other than a tick answers in the very next cycle.
  a_fast_reply: assert property (@(posedge clk) disable iff (rst)
      (start && !busy && cmd.kind != KIND_TICK) |=> done)
    else $error("non-tick request did not answer in one cycle");

  // A failed request never reports a created slot.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
      (done && rsp.failed) |-> (rsp.created_thread == 5'd0))
    else $error("failed request reports a slot");

  // The running thread is a real slot or idle.
  a_run_range: assert property (@(posedge clk) disable iff (rst)
      done |-> (rsp.running_thread < 6'(NUM_THREADS) || rsp.running_thread == IDLE_ID))
    else $error("running thread out of range");

  // A tick's walk starts without a result.
  a_tick_quiet: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> !done)
    else $error("result at start of tick walk");

endmodule

bind credit_thread_scheduler_unit ctsu_checker u_ctsu_checker (.*);

// File: tb/sv/tb_credit_thread_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_credit_thread_scheduler_unit
// Drives random and directed scheduler requests into the thread scheduler and
// checks every result against a cycle-free model of the bitmaps and credits.
// ----------------------------------------------------------------------------

class sched_scoreboard;
  logic [31:0] ready_set, wait_set, sleep_set, alloc_set, cancel_set;
  logic [7:0]  prio [16];
  int          credit [16];
  logic [7:0]  climit;
  logic [5:0]  cur;
  ctsu_pkg::rsp_t pending[$];
  int errors;
  int checked;

  function void reset_state();
    ready_set = '0; wait_set = '0; sleep_set = '0; cancel_set = '0;
    alloc_set = (32'hffffffff << ctsu_pkg::NUM_THREADS) | 32'd1;
    foreach (prio[i]) begin
      prio[i] = '0;
      credit[i] = 0;
    end
    prio[0] = 8'd1;
    climit = 8'd1;
    cur = '0;
  endfunction

  function int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function logic [5:0] first_one(logic [31:0] m);
    for (int i = 0; i < 32; i++) if (m[i]) return 6'(i);
    return ctsu_pkg::IDLE_ID;
  endfunction

  function void pick();
    cur = first_one(ready_set);
    if (cur < 6'd32) ready_set[cur[4:0]] = 1'b0;
  endfunction

  // Apply one accepted request and queue the result it must produce.
  function void note_request(ctsu_pkg::cmd_t c);
    ctsu_pkg::rsp_t r;
    logic [5:0] idx;
    int v;
    bit slot;
    r = '0;
    slot = cur < 6'(ctsu_pkg::NUM_THREADS);
    case (c.kind)
      ctsu_pkg::KIND_TICK: begin
        for (int j = 0; j < ctsu_pkg::NUM_THREADS; j++) begin
          if (sleep_set[j]) begin
            credit[j] = clamp16(credit[j] - 1);
            if (credit[j] <= 0) begin
              sleep_set[j] = 1'b0;
              ready_set[j] = 1'b1;
            end
          end
        end
        if (slot) begin
          v = credit[cur] - int'(prio[cur]);
          if (v < 0) begin
            v += int'(climit);
            wait_set[cur[4:0]] = 1'b1;
          end else begin
            ready_set[cur[4:0]] = 1'b1;
          end
          credit[cur] = clamp16(v);
        end
        if (ready_set == 0) begin
          ready_set = wait_set;
          wait_set = '0;
        end
        pick();
      end
      ctsu_pkg::KIND_YIELD: begin
        if (slot) ready_set[cur[4:0]] = 1'b1;
        pick();
      end
      ctsu_pkg::KIND_BLOCK: pick();
      ctsu_pkg::KIND_CREATE: begin
        idx = ctsu_pkg::IDLE_ID;
        if (c.priority_req == 0) begin
          idx = first_one(~alloc_set);
        end else begin
          for (int j = 31; j >= 0; j--) begin
            if (!alloc_set[j]) begin
              idx = 6'(j);
              break;
            end
          end
        end
        if (idx >= 6'(ctsu_pkg::NUM_THREADS)) begin
          r.failed = 1'b1;
        end else begin
          alloc_set[idx[4:0]] = 1'b1;
          prio[idx] = c.priority_req;
          if (climit < c.priority_req) climit = c.priority_req;
          credit[idx] = int'(climit) / 2;
          ready_set[idx[4:0]] = 1'b1;
          r.created_thread = idx[4:0];
        end
      end
      ctsu_pkg::KIND_SLEEP: begin
        if (slot) begin
          credit[cur] = (int'(c.sleep_ms) + 1) / 100;
          sleep_set[cur[4:0]] = 1'b1;
        end
      end
      ctsu_pkg::KIND_CANCEL: begin
        if (!alloc_set[c.target_thread]) begin
          r.failed = 1'b1;
        end else begin
          wait_set[c.target_thread] = 1'b0;
          sleep_set[c.target_thread] = 1'b0;
          ready_set[c.target_thread] = 1'b0;
          cancel_set[c.target_thread] = 1'b1;
        end
      end
      default: ;
    endcase
    r.running_thread = cur;
    pending.push_back(r);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(ctsu_pkg::rsp_t got);
    ctsu_pkg::rsp_t want;
    if (pending.size() == 0) begin
      report("unexpected result", 32'(got), 32'd0);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.running_thread !== want.running_thread)
      report("running_thread", 32'(got.running_thread), 32'(want.running_thread));
    if (got.created_thread !== want.created_thread)
      report("created_thread", 32'(got.created_thread), 32'(want.created_thread));
    if (got.failed !== want.failed) report("failed", 32'(got.failed), 32'(want.failed));
  endtask
endclass

module tb_credit_thread_scheduler_unit;
  import ctsu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  cmd_t cmd = '0;
  rsp_t rsp;

  sched_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;
  int kinds_seen [8];

  credit_thread_scheduler_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check_result(rsp);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_credit_thread_scheduler_unit: done, errors");
      $finish;
    end
  end

  // Present one request and hold it until it is taken. Start stays high
  // after the request is taken so that requests can follow back to back.
  task send_request(cmd_t c);
    while (!calm && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c);
    kinds_seen[c.kind]++;
    @(negedge clk);
  endtask

  function cmd_t make_cmd(logic [2:0] k, logic [7:0] p, logic [15:0] ms,
                          logic [4:0] t);
    cmd_t c;
    c.kind = k; c.priority_req = p; c.sleep_ms = ms; c.target_thread = t;
    return c;
  endfunction

  function cmd_t random_cmd();
    cmd_t c;
    int r;
    c = cmd_t'($urandom);
    r = $urandom_range(99);
    if (r < 35) c.kind = KIND_TICK;
    else if (r < 47) c.kind = KIND_YIELD;
    else if (r < 57) c.kind = KIND_BLOCK;
    else if (r < 72) c.kind = KIND_CREATE;
    else if (r < 84) c.kind = KIND_SLEEP;
    else if (r < 96) c.kind = KIND_CANCEL;
    // Short sleeps so sleepers wake within a few ticks.
    if (c.kind == KIND_SLEEP && $urandom_range(3) != 0)
      c.sleep_ms = 16'($urandom_range(800));
    if (c.kind == KIND_CREATE && $urandom_range(3) == 0)
      c.priority_req = 8'($urandom_range(3));
    return c;
  endfunction

  initial begin
    sb.reset_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every kind, overflow and cancel corner cases.
    send_request(make_cmd(KIND_SLEEP, 8'd0, 16'hffff, 5'd0));
    send_request(make_cmd(KIND_TICK, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_CREATE, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_CREATE, 8'd255, 16'hffff, 5'd31));
    send_request(make_cmd(KIND_CREATE, 8'd1, 16'd0, 5'd0));
    send_request(make_cmd(KIND_YIELD, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_TICK, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_SLEEP, 8'd0, 16'd98, 5'd0));
    send_request(make_cmd(KIND_BLOCK, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_CANCEL, 8'd0, 16'd0, 5'd31));
    send_request(make_cmd(KIND_CANCEL, 8'd0, 16'd0, 5'd9));
    send_request(make_cmd(KIND_CANCEL, 8'd0, 16'd0, 5'd15));
    send_request(make_cmd(3'd6, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(3'd7, 8'hff, 16'hffff, 5'h1f));
    for (int i = 0; i < 16; i++)
      send_request(make_cmd(KIND_CREATE, 8'(i), 16'd0, 5'd0));
    for (int i = 0; i < 4; i++) send_request(make_cmd(KIND_BLOCK, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_CANCEL, 8'd0, 16'd0, 5'd0));
    send_request(make_cmd(KIND_BLOCK, 8'd0, 16'd0, 5'd0));

    // Random part; a calm stretch without gaps, then a drain pause.
    for (int n = 0; n < 1530; n++) begin
      calm = (n >= 400 && n < 600);
      if (n == 800) begin
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
      end
      send_request(random_cmd());
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (2 * NUM_THREADS + 10) @(negedge clk);
    $display("covered %0d results: tick %0d yield %0d block %0d create %0d", sb.checked,
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
    $display("sleep %0d cancel %0d unknown kinds %0d", kinds_seen[4], kinds_seen[5],
             kinds_seen[6] + kinds_seen[7]);
    if (sb.errors == 0) begin
      $display("tb_credit_thread_scheduler_unit: done, clean");
    end else begin
      $display("tb_credit_thread_scheduler_unit: done, errors");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/ctsu_pkg.sv
hdl/credit_thread_scheduler_unit.sv
hdl/ctsu_checker.sv
tb/sv/tb_credit_thread_scheduler_unit.sv
